[hdl/snnt_pkg.sv]
// Package for the sorted name/number table.
// Holds record types, op and status codes, and the cell control struct.
package snnt_pkg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_FIND   = 2'd1,
        OP_DELETE = 2'd2,
        OP_LIST   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2
    } status_t;

    typedef struct packed {
        logic [63:0] w0;
        logic [63:0] w1;
        logic [23:0] w2;
    } word152_t;

    typedef struct packed {
        word152_t name;
        word152_t number;
    } record_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic ins;   // insert step
        logic del;   // delete step
        logic shl;   // list rotate step
    } cell_cmd_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_OUT,
        S_LIST
    } state_t;

endpackage

[hdl/snnt_cell.sv]
// One table slot: holds a record and compares it against the key.
// Depends on snnt_pkg.
module snnt_cell (
    input  logic               clk,
    input  snnt_pkg::cell_cmd_t cmd,
    input  snnt_pkg::word152_t  key,
    input  snnt_pkg::record_t   new_rec,
    input  logic               my_used,
    input  logic               left_gt,   // slot below holds a name above key
    input  snnt_pkg::record_t   left_rec,
    input  snnt_pkg::record_t   right_rec,
    input  logic               right_used,
    input  logic               del_here,  // this or a lower slot is deleted
    output snnt_pkg::record_t   rec,
    output logic               gt,        // used and name above key
    output logic               eq
);
    snnt_pkg::record_t rec_reg;
    snnt_pkg::record_t rec_next;
    logic              is_gt;

    assign is_gt = rec_reg.name > key;
    assign gt    = my_used && is_gt;
    assign eq    = my_used && (rec_reg.name == key);
    assign rec   = rec_reg;

    always_comb
    begin
        rec_next = rec_reg;
        if (cmd.ins)
        begin
            if (left_gt)
                rec_next = left_rec;
            else if (!my_used || is_gt)
                rec_next = new_rec;
        end
        else if (cmd.del)
        begin
            if (del_here && right_used)
                rec_next = right_rec;
        end
        else if (cmd.shl)
        begin
            rec_next = right_rec;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end
endmodule

[hdl/sorted_name_number_table_unit.sv]
// Top level of the sorted name/number table.
// Depends on snnt_pkg and snnt_cell.
//
// A row of TABLE_DEPTH cells holds records in ascending name order; every cell
// compares its name with the key at once. Insert, find and delete do their
// compare/shift in the execute state after the accept, while the result word
// is loaded into the output register; the input stays stalled until that word
// is taken, so a new word is accepted only after the previous result has gone. A
// list emits one word per cycle, while the output is not stalled, by rotating
// the chain down toward slot 0, so a full rotation of count steps restores
// the table. Slots at or above the count are unused. Insert into a full table
// returns status full; find or delete of a missing name returns not found.
module sorted_name_number_table_unit #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic [63:0] name_w0,
    input  logic [63:0] name_w1,
    input  logic [23:0] name_w2,
    input  logic [63:0] number_w0,
    input  logic [63:0] number_w1,
    input  logic [23:0] number_w2,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [63:0] out_name_w0,
    output logic [63:0] out_name_w1,
    output logic [23:0] out_name_w2,
    output logic [63:0] out_number_w0,
    output logic [63:0] out_number_w1,
    output logic [23:0] out_number_w2,
    output logic [6:0]  record_count,
    output logic        last
);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    snnt_pkg::state_t   state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      left_reg, left_next;   // words left in a listing
    snnt_pkg::op_t      op_reg;
    snnt_pkg::record_t  in_rec_reg;
    snnt_pkg::cell_cmd_t cmd;

    snnt_pkg::record_t  recs [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] used, gtv, eqv, first_eq, del_at;

    // output register
    logic               ov_reg, ov_next;
    logic [1:0]         st_reg, st_next;
    snnt_pkg::record_t  orec_reg, orec_next;
    logic               last_reg, last_next;
    logic               hit;
    snnt_pkg::word152_t found_num;

    always_comb
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
            used[i] = CW'(i) < count_reg;
    end

    // first match one-hot and the "at or above the deleted slot" mask
    always_comb
    begin
        logic seen;
        seen      = 1'b0;
        found_num = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            first_eq[i] = eqv[i] && !seen;
            if (first_eq[i])
                found_num = recs[i].number;
            seen      = seen || eqv[i];
            del_at[i] = seen;
        end
        hit = seen;
    end

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++)
        begin : g_cell
            snnt_pkg::record_t lrec, rrec;
            logic lgt, rused;
            if (g == 0)
            begin : g_lo
                assign lrec = '0;
                assign lgt  = 1'b0;
            end
            else
            begin : g_mid
                assign lrec = recs[g-1];
                assign lgt  = gtv[g-1];
            end
            if (g == TABLE_DEPTH - 1)
            begin : g_hi
                assign rrec  = recs[0];
                assign rused = 1'b0;
            end
            else
            begin : g_in
                assign rrec  = recs[g+1];
                assign rused = used[g+1];
            end
            snnt_cell u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .key        (in_rec_reg.name),
                .new_rec    (in_rec_reg),
                .my_used    (used[g]),
                .left_gt    (lgt),
                .left_rec   (lrec),
                .right_rec  ((cmd.shl && CW'(g + 1) == count_reg) ? recs[0] : rrec),
                .right_used (rused),
                .del_here   (del_at[g]),
                .rec        (recs[g]),
                .gt         (gtv[g]),
                .eq         (eqv[g])
            );
        end
    endgenerate

    assign in_stall = (state_reg != snnt_pkg::S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= snnt_pkg::S_IDLE;
            count_reg <= '0;
            left_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            left_reg  <= left_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            op_reg     <= snnt_pkg::op_t'(op);
            in_rec_reg <= {name_w0, name_w1, name_w2, number_w0, number_w1, number_w2};
        end
        st_reg   <= st_next;
        orec_reg <= orec_next;
        last_reg <= last_next;
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        left_next  = left_reg;
        ov_next    = ov_reg && out_stall;
        st_next    = st_reg;
        orec_next  = orec_reg;
        last_next  = last_reg;
        cmd        = '0;
        case (state_reg)
            snnt_pkg::S_IDLE:
            begin
                if (in_valid)
                    state_next = snnt_pkg::S_EXEC;
            end
            snnt_pkg::S_EXEC:
            begin
                // result register is free here: previous word was taken
                st_next   = snnt_pkg::ST_OK;
                orec_next = '0;
                last_next = 1'b1;
                ov_next   = 1'b1;
                state_next = snnt_pkg::S_OUT;
                case (op_reg)
                    snnt_pkg::OP_INSERT:
                    begin
                        if (count_reg >= CW'(TABLE_DEPTH))
                            st_next = snnt_pkg::ST_FULL;
                        else
                        begin
                            cmd.ins    = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    snnt_pkg::OP_FIND:
                    begin
                        if (hit)
                            orec_next.number = found_num;
                        else
                            st_next = snnt_pkg::ST_NOTFOUND;
                    end
                    snnt_pkg::OP_DELETE:
                    begin
                        if (hit)
                        begin
                            cmd.del    = 1'b1;
                            count_next = count_reg - 1'b1;
                        end
                        else
                            st_next = snnt_pkg::ST_NOTFOUND;
                    end
                    snnt_pkg::OP_LIST:
                    begin
                        if (count_reg != '0)
                        begin
                            orec_next  = recs[0];
                            last_next  = (count_reg == CW'(1));
                            cmd.shl    = 1'b1;
                            left_next  = count_reg - 1'b1;
                            state_next = snnt_pkg::S_LIST;
                        end
                    end
                    default: ;
                endcase
            end
            snnt_pkg::S_LIST:
            begin
                if (!out_stall)
                begin
                    if (left_reg == '0)
                        state_next = snnt_pkg::S_IDLE;
                    else
                    begin
                        orec_next = recs[0];
                        last_next = (left_reg == CW'(1));
                        ov_next   = 1'b1;
                        cmd.shl   = 1'b1;
                        left_next = left_reg - 1'b1;
                    end
                end
            end
            snnt_pkg::S_OUT:
            begin
                if (!out_stall)
                    state_next = snnt_pkg::S_IDLE;
            end
            default: state_next = snnt_pkg::S_IDLE;
        endcase
    end

    assign out_valid     = ov_reg;
    assign status        = st_reg;
    assign out_name_w0   = orec_reg.name.w0;
    assign out_name_w1   = orec_reg.name.w1;
    assign out_name_w2   = orec_reg.name.w2;
    assign out_number_w0 = orec_reg.number.w0;
    assign out_number_w1 = orec_reg.number.w1;
    assign out_number_w2 = orec_reg.number.w2;
    assign record_count  = 7'(count_reg);
    assign last          = last_reg;
endmodule

[bench/sorted_name_number_table_unit_tb.sv]
// Testbench for sorted_name_number_table_unit: drives insert, find, delete and list words
// and checks every result word against a behavioral table kept in the bench.
// Depends on snnt_pkg and the RTL of the table unit.
module sorted_name_number_table_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 64;
    localparam int CYCLE_LIMIT = 600000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  op = snnt_pkg::OP_INSERT;
    logic [63:0] name_w0 = '0;
    logic [63:0] name_w1 = '0;
    logic [23:0] name_w2 = '0;
    logic [63:0] number_w0 = '0;
    logic [63:0] number_w1 = '0;
    logic [23:0] number_w2 = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic [63:0] out_name_w0;
    logic [63:0] out_name_w1;
    logic [23:0] out_name_w2;
    logic [63:0] out_number_w0;
    logic [63:0] out_number_w1;
    logic [23:0] out_number_w2;
    logic [6:0]  record_count;
    logic        last;

    sorted_name_number_table_unit #(.TABLE_DEPTH(DEPTH)) dut (.*);

    always #5 clk = ~clk;

    // One expected result word.
    typedef struct {
        snnt_pkg::status_t  st;
        snnt_pkg::word152_t nm;
        snnt_pkg::word152_t num;
        logic [6:0] cnt;
        logic     lst;
    } reply_t;

    // Behavioral copy of the table: records in ascending name order.
    snnt_pkg::record_t table_rec[DEPTH];
    int      rec_count;
    reply_t  pending_replies[$];

    int  errors = 0;
    int  words_sent = 0;
    int  replies_seen = 0;
    int  lists_seen = 0;
    int  fulls_seen = 0;
    int  misses_seen = 0;
    bit  quiet_tail = 0;  // no idling in the last part of the run
    longint cycles = 0;

    // Recently inserted names, reused so find and delete hit often.
    snnt_pkg::word152_t name_pool[$];

    function automatic reply_t mk_reply(snnt_pkg::status_t st, snnt_pkg::word152_t nm,
                                        snnt_pkg::word152_t num, bit lst);
        reply_t r;
        r.st = st; r.nm = nm; r.num = num; r.cnt = rec_count[6:0]; r.lst = lst;
        return r;
    endfunction

    // Apply one word to the table copy and queue the results it causes.
    task automatic predict_table_op(snnt_pkg::op_t o, snnt_pkg::word152_t key,
                                    snnt_pkg::word152_t num);
        int i;
        int hit;
        hit = -1;
        for (i = 0; i < rec_count; i++)
            if (hit < 0 && table_rec[i].name == key) hit = i;
        case (o)
            snnt_pkg::OP_INSERT: begin
                if (rec_count >= DEPTH) begin
                    pending_replies.push_back(mk_reply(snnt_pkg::ST_FULL, '0, '0, 1'b1));
                    fulls_seen++;
                end else begin
                    // packed compare of {w0,w1,w2} is the byte-string order
                    i = rec_count;
                    while (i > 0 && table_rec[i-1].name > key) begin
                        table_rec[i] = table_rec[i-1];
                        i--;
                    end
                    table_rec[i].name = key;
                    table_rec[i].number = num;
                    rec_count++;
                    pending_replies.push_back(mk_reply(snnt_pkg::ST_OK, '0, '0, 1'b1));
                end
            end
            snnt_pkg::OP_FIND: begin
                if (hit < 0) begin
                    pending_replies.push_back(mk_reply(snnt_pkg::ST_NOTFOUND, '0, '0, 1'b1));
                    misses_seen++;
                end else
                    pending_replies.push_back(mk_reply(snnt_pkg::ST_OK, '0,
                        table_rec[hit].number, 1'b1));
            end
            snnt_pkg::OP_DELETE: begin
                if (hit < 0) begin
                    pending_replies.push_back(mk_reply(snnt_pkg::ST_NOTFOUND, '0, '0, 1'b1));
                    misses_seen++;
                end else begin
                    for (i = hit; i + 1 < rec_count; i++) table_rec[i] = table_rec[i+1];
                    rec_count--;
                    pending_replies.push_back(mk_reply(snnt_pkg::ST_OK, '0, '0, 1'b1));
                end
            end
            default: begin
                lists_seen++;
                if (rec_count == 0)
                    pending_replies.push_back(mk_reply(snnt_pkg::ST_OK, '0, '0, 1'b1));
                for (i = 0; i < rec_count; i++)
                    pending_replies.push_back(mk_reply(snnt_pkg::ST_OK, table_rec[i].name,
                        table_rec[i].number, i + 1 == rec_count));
            end
        endcase
    endtask

    // Send one word; inputs change on the falling edge, acceptance seen at the rising edge.
    task automatic send_word(snnt_pkg::op_t o, snnt_pkg::word152_t key,
                             snnt_pkg::word152_t num);
        int gap;
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 5);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        op        <= o;
        name_w0   <= key.w0;
        name_w1   <= key.w1;
        name_w2   <= key.w2;
        number_w0 <= num.w0;
        number_w1 <= num.w1;
        number_w2 <= num.w2;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_table_op(o, key, num);
        words_sent++;
        if (o == snnt_pkg::OP_INSERT) begin
            name_pool.push_back(key);
            if (name_pool.size() > 24) void'(name_pool.pop_front());
        end
        @(negedge clk);
        in_valid <= 1'b0;
        // the unit stalls after an accept, so this costs no throughput
        @(negedge clk);
    endtask

    function automatic snnt_pkg::word152_t rand_word();
        snnt_pkg::word152_t w;
        w.w0 = {$urandom, $urandom};
        w.w1 = {$urandom, $urandom};
        w.w2 = 24'($urandom);
        return w;
    endfunction

    // Short names with few letters, or long random ones, so duplicates and ordering ties show up.
    function automatic snnt_pkg::word152_t rand_name();
        snnt_pkg::word152_t w;
        w = '0;
        case ($urandom_range(0, 3))
            0: w.w0 = {8'h41 + 8'($urandom_range(0, 3)), 56'h0};
            1: w.w0 = {8'h41 + 8'($urandom_range(0, 3)), 8'h61 + 8'($urandom_range(0, 3)),
                       48'h0};
            2: begin w.w0 = {$urandom, $urandom}; w.w1 = {$urandom_range(0, 3), 32'h0}; end
            default: w = rand_word();
        endcase
        return w;
    endfunction

    function automatic snnt_pkg::word152_t known_or_new();
        if (name_pool.size() > 0 && $urandom_range(0, 3) != 0)
            return name_pool[$urandom_range(0, name_pool.size() - 1)];
        return rand_name();
    endfunction

    // Output side: random stall bursts, changed on the falling edge.
    initial begin
        int n;
        forever begin
            @(negedge clk);
            if (!quiet_tail && $urandom_range(0, 6) == 0) begin
                n = $urandom_range(1, 5);
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    // Result checker: compare each accepted word with the oldest expectation.
    always @(posedge clk) begin
        reply_t e;
        if (rst_n && out_valid && !out_stall) begin
            replies_seen++;
            if (pending_replies.size() == 0) begin
                $display("%0t: unexpected result word, expected none, got status %0d",
                         $time, status);
                errors++;
            end else begin
                e = pending_replies.pop_front();
                if (status !== e.st || out_name_w0 !== e.nm.w0 || out_name_w1 !== e.nm.w1 ||
                    out_name_w2 !== e.nm.w2 || out_number_w0 !== e.num.w0 ||
                    out_number_w1 !== e.num.w1 || out_number_w2 !== e.num.w2 ||
                    record_count !== e.cnt || last !== e.lst) begin
                    $display("%0t: expected st=%0d name=%h_%h_%h num=%h_%h_%h cnt=%0d last=%0d",
                             $time, e.st, e.nm.w0, e.nm.w1, e.nm.w2,
                             e.num.w0, e.num.w1, e.num.w2, e.cnt, e.lst);
                    $display("%0t: actual   st=%0d name=%h_%h_%h num=%h_%h_%h cnt=%0d last=%0d",
                             $time, status, out_name_w0, out_name_w1, out_name_w2,
                             out_number_w0, out_number_w1, out_number_w2, record_count, last);
                    errors++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("sorted_name_number_table_unit: mismatch");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_replies.size() != 0) @(negedge clk);
    endtask

    // Empty-table cases and field extremes.
    task automatic test_edges();
        snnt_pkg::word152_t ones;
        snnt_pkg::word152_t zero;
        ones = '1;
        zero = '0;
        send_word(snnt_pkg::OP_LIST, zero, zero);
        send_word(snnt_pkg::OP_FIND, ones, zero);
        send_word(snnt_pkg::OP_DELETE, zero, zero);
        send_word(snnt_pkg::OP_INSERT, ones, ones);
        send_word(snnt_pkg::OP_INSERT, zero, zero);
        send_word(snnt_pkg::OP_INSERT, ones, rand_word());  // duplicate keeps arrival order
        send_word(snnt_pkg::OP_FIND, ones, zero);
        send_word(snnt_pkg::OP_FIND, zero, ones);           // number ignored on find
        send_word(snnt_pkg::OP_LIST, zero, ones);
        send_word(snnt_pkg::OP_DELETE, ones, zero);
        send_word(snnt_pkg::OP_FIND, ones, zero);
        send_word(snnt_pkg::OP_DELETE, zero, zero);
        send_word(snnt_pkg::OP_DELETE, ones, zero);
        send_word(snnt_pkg::OP_LIST, zero, zero);
    endtask

    // Fill the table, overflow it, list it full, then empty it again.
    task automatic test_full_table();
        int i;
        snnt_pkg::word152_t key;
        for (i = 0; i < DEPTH + 2; i++)
            send_word(snnt_pkg::OP_INSERT, rand_name(), rand_word());
        send_word(snnt_pkg::OP_LIST, '0, '0);
        // pause until the full listing has come back
        wait_drained();
        while (rec_count > 0) begin
            key = table_rec[$urandom_range(0, rec_count - 1)].name;
            send_word(snnt_pkg::OP_DELETE, key, '0);
        end
        send_word(snnt_pkg::OP_LIST, '0, '0);
    endtask

    task automatic test_random_mix(int count);
        int i;
        int pick;
        for (i = 0; i < count; i++) begin
            if (i > count * 3 / 4) quiet_tail = 1;
            pick = $urandom_range(0, 19);
            if (pick < 8)
                send_word(snnt_pkg::OP_INSERT, rand_name(), rand_word());
            else if (pick < 13)
                send_word(snnt_pkg::OP_FIND, known_or_new(), rand_word());
            else if (pick < 18)
                send_word(snnt_pkg::OP_DELETE, known_or_new(), rand_word());
            else
                send_word(snnt_pkg::OP_LIST, rand_word(), rand_word());
        end
    endtask

    initial begin
        rec_count = 0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_edges();
        test_full_table();
        test_random_mix(284);
        wait_drained();
        repeat (20) @(posedge clk);
        $display("Sent %0d words, checked %0d result words: %0d listings,", words_sent,
                 replies_seen, lists_seen);
        $display("%0d table-full and %0d not-found replies.", fulls_seen, misses_seen);
        if (errors == 0)
            $display("sorted_name_number_table_unit: match");
        else
            $display("sorted_name_number_table_unit: mismatch");
        $finish;
    end

endmodule

[sorted_name_number_table_unit.f]
hdl/snnt_pkg.sv
hdl/snnt_cell.sv
hdl/sorted_name_number_table_unit.sv
bench/sorted_name_number_table_unit_tb.sv
